/* rtl/oal_pkg.sv */
package oal_pkg;

  // fixed port widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int KEY_W   = 64;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

  // read address source
  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_CNT_M1,
    RD_POS_P1,
    RD_ZERO,
    RD_DOWN,
    RD_UP
  } rd_sel_t;

  // write kind
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ENTRY,
    WR_PTIME,
    WR_SHIFT_UP,
    WR_SHIFT_DN
  } wr_sel_t;

  // result kind
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_GET,
    RES_FOUND
  } res_t;

  typedef struct packed {
    logic    accept;
    logic    clr_count;
    logic    inc_count;
    logic    dec_count;
    logic    finish;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    res_t    res;
  } cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic ins_direct;
    logic pos_ok;
    logic del_last;
    logic empty;
    logic last_up;
    logic last_dn;
    logic match;
  } stat_t;

endpackage

/* rtl/oal_ram.sv */
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/oal_ctrl.sv */
module oal_ctrl
  import oal_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  stat_t           stat,
  output logic            busy,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GET  = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_FIND = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_sel    = RD_NONE;
    cmd.wr_sel    = WR_NONE;
    cmd.res       = RES_FAIL;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (op)
            OP_CLEAR: begin
              cmd.clr_count = 1'b1;
              cmd.finish    = 1'b1;
              cmd.res       = RES_OK;
            end
            OP_INSERT: begin
              if (!stat.ins_ok) begin
                cmd.finish = 1'b1;
              end else if (stat.ins_direct) begin
                cmd.wr_sel    = WR_ENTRY;
                cmd.inc_count = 1'b1;
                cmd.finish    = 1'b1;
                cmd.res       = RES_OK;
              end else begin
                cmd.rd_sel = RD_CNT_M1;
                state_next = S_UP;
              end
            end
            OP_DELETE: begin
              if (!stat.pos_ok) begin
                cmd.finish = 1'b1;
              end else if (stat.del_last) begin
                cmd.dec_count = 1'b1;
                cmd.finish    = 1'b1;
                cmd.res       = RES_OK;
              end else begin
                cmd.rd_sel = RD_POS_P1;
                state_next = S_DN;
              end
            end
            OP_GET: begin
              if (!stat.pos_ok) begin
                cmd.finish = 1'b1;
              end else begin
                cmd.rd_sel = RD_POS;
                state_next = S_GET;
              end
            end
            OP_UPDATE: begin
              cmd.finish = 1'b1;
              if (stat.pos_ok) begin
                cmd.wr_sel = WR_PTIME;
                cmd.res    = RES_OK;
              end
            end
            OP_FIND: begin
              if (stat.empty) begin
                cmd.finish = 1'b1;
                cmd.res    = RES_OK;
              end else begin
                cmd.rd_sel = RD_ZERO;
                state_next = S_FIND;
              end
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        cmd.finish = 1'b1;
        cmd.res    = RES_GET;
        state_next = S_IDLE;
      end
      S_UP: begin
        cmd.wr_sel = WR_SHIFT_UP;
        if (stat.last_up) begin
          state_next = S_INS;
        end else begin
          cmd.rd_sel = RD_DOWN;
        end
      end
      S_INS: begin
        cmd.wr_sel    = WR_ENTRY;
        cmd.inc_count = 1'b1;
        cmd.finish    = 1'b1;
        cmd.res       = RES_OK;
        state_next    = S_IDLE;
      end
      S_DN: begin
        cmd.wr_sel = WR_SHIFT_DN;
        if (stat.last_dn) begin
          cmd.dec_count = 1'b1;
          cmd.finish    = 1'b1;
          cmd.res       = RES_OK;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_sel = RD_UP;
        end
      end
      S_FIND: begin
        if (stat.match) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_FOUND;
          state_next = S_IDLE;
        end else if (stat.last_dn) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_OK;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_UP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a finishing step always hands control back
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("controller not idle after finish");

  // busy only follows an accepted start
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule

/* rtl/oal_dp.sv */
module oal_dp
  import oal_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int TITLE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [POS_W-1:0]   position,
  input  logic               append,
  input  logic [KEY_W-1:0]   title_key,
  input  logic [WORD_W-1:0]  play_time_in,
  input  logic [WORD_W-1:0]  payload_in,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               done,
  output logic               ok,
  output logic               found,
  output logic [POS_W-1:0]   found_position,
  output logic [KEY_W-1:0]   title_out,
  output logic [WORD_W-1:0]  play_time_out,
  output logic [WORD_W-1:0]  payload_out,
  output logic [COUNT_W-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         entry_count_next;
  logic [AW-1:0]         rd_addr;
  logic [TITLE_BITS-1:0] key_q;
  logic [WORD_W-1:0]     ptime_q;
  logic [WORD_W-1:0]     pay_q;
  logic [AW-1:0]         at_q;

  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [PW-1:0]         at_x;
  logic [AW-1:0]         cnt_m1;
  logic [AW-1:0]         pos_a;

  logic                  re;
  logic [AW-1:0]         raddr;
  logic                  we_all;
  logic                  we_pt;
  logic [AW-1:0]         waddr;
  logic [TITLE_BITS-1:0] wr_title;
  logic [WORD_W-1:0]     wr_ptime;
  logic [WORD_W-1:0]     wr_pay;
  logic [TITLE_BITS-1:0] rd_title;
  logic [WORD_W-1:0]     rd_ptime;
  logic [WORD_W-1:0]     rd_pay;

  assign pos_x  = PW'(position);
  assign cnt_x  = PW'(entry_count);
  assign at_x   = append ? cnt_x : pos_x;
  assign cnt_m1 = AW'(entry_count - CW'(1));
  assign pos_a  = AW'(position);

  assign stat.ins_ok     = (entry_count != CW'(DEPTH)) && (at_x <= cnt_x);
  assign stat.ins_direct = (at_x == cnt_x);
  assign stat.pos_ok     = (pos_x < cnt_x);
  assign stat.del_last   = (pos_a == cnt_m1);
  assign stat.empty      = (entry_count == '0);
  assign stat.last_up    = (rd_addr == at_q);
  assign stat.last_dn    = (rd_addr == cnt_m1);
  assign stat.match      = (rd_title == key_q);

  // read port
  always_comb begin
    re    = 1'b1;
    raddr = rd_addr;
    case (cmd.rd_sel)
      RD_POS:    raddr = pos_a;
      RD_CNT_M1: raddr = cnt_m1;
      RD_POS_P1: raddr = pos_a + AW'(1);
      RD_ZERO:   raddr = '0;
      RD_DOWN:   raddr = rd_addr - AW'(1);
      RD_UP:     raddr = rd_addr + AW'(1);
      default:   re    = 1'b0;
    endcase
  end

  // write port; a new entry takes live inputs on the accept cycle
  always_comb begin
    we_all   = 1'b0;
    we_pt    = 1'b0;
    waddr    = at_q;
    wr_title = rd_title;
    wr_ptime = rd_ptime;
    wr_pay   = rd_pay;
    case (cmd.wr_sel)
      WR_ENTRY: begin
        we_all   = 1'b1;
        we_pt    = 1'b1;
        waddr    = cmd.accept ? AW'(at_x) : at_q;
        wr_title = cmd.accept ? title_key[TITLE_BITS-1:0] : key_q;
        wr_ptime = cmd.accept ? play_time_in : ptime_q;
        wr_pay   = cmd.accept ? payload_in : pay_q;
      end
      WR_PTIME: begin
        we_pt    = 1'b1;
        waddr    = pos_a;
        wr_ptime = play_time_in;
      end
      WR_SHIFT_UP: begin
        we_all = 1'b1;
        we_pt  = 1'b1;
        waddr  = rd_addr + AW'(1);
      end
      WR_SHIFT_DN: begin
        we_all = 1'b1;
        we_pt  = 1'b1;
        waddr  = rd_addr - AW'(1);
      end
      default: begin
        we_all = 1'b0;
      end
    endcase
  end

  oal_ram #(.WIDTH(TITLE_BITS), .DEPTH(DEPTH)) u_title_ram (
    .clk   (clk),
    .we    (we_all),
    .waddr (waddr),
    .wdata (wr_title),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_title)
  );

  oal_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ptime_ram (
    .clk   (clk),
    .we    (we_pt),
    .waddr (waddr),
    .wdata (wr_ptime),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_ptime)
  );

  oal_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (we_all),
    .waddr (waddr),
    .wdata (wr_pay),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_pay)
  );

  always_comb begin
    entry_count_next = entry_count;
    if (cmd.clr_count) begin
      entry_count_next = '0;
    end else if (cmd.inc_count) begin
      entry_count_next = entry_count + CW'(1);
    end else if (cmd.dec_count) begin
      entry_count_next = entry_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= cmd.finish;
    end
  end

  // operand latch and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_q   <= title_key[TITLE_BITS-1:0];
      ptime_q <= play_time_in;
      pay_q   <= payload_in;
      at_q    <= AW'(at_x);
    end
    if (re) begin
      rd_addr <= raddr;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ok             <= 1'b1;
      found          <= 1'b0;
      found_position <= '0;
      title_out      <= '0;
      play_time_out  <= '0;
      payload_out    <= '0;
      count          <= COUNT_W'(entry_count_next);
      case (cmd.res)
        RES_FAIL: ok <= 1'b0;
        RES_GET: begin
          title_out     <= KEY_W'(rd_title);
          play_time_out <= rd_ptime;
          payload_out   <= rd_pay;
        end
        RES_FOUND: begin
          found          <= 1'b1;
          found_position <= POS_W'(rd_addr);
        end
        default: ok <= 1'b1;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count above depth");

  // a shift never reads the entry it overwrites in the same cycle
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (re && we_all) |-> (raddr != waddr))
    else $error("read and write at same address");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.inc_count && cmd.dec_count))
    else $error("count incremented and decremented together");

endmodule

/* rtl/ordered_array_list.sv */
// Channel   Handshake                Beat contents
// command   start / busy             op, position, append, title_key,
//                                    play_time_in, payload_in
// result    done (one-cycle strobe)  ok, found, found_position, title_out,
//                                    play_time_out, payload_out, count
//
// A command is taken when start is high and busy is low; its result shows
// for one cycle with done, in the cycle after the last working cycle.
// Steps share the single read port of the entry RAMs. Clear, update,
// failed ops, an empty find and an insert or delete at the end finish on
// accept; get reads one entry; insert shifts entries up from the last to
// the position, then writes; delete shifts down; find scans from entry 0.
// Reset clears the entry count, the controller and done; the RAMs are not
// cleared. The receiver cannot stall: a result beat is taken as shown.
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int TITLE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [POS_W-1:0]   position,
  input  logic               append,
  input  logic [KEY_W-1:0]   title_key,
  input  logic [WORD_W-1:0]  play_time_in,
  input  logic [WORD_W-1:0]  payload_in,
  output logic               done,
  output logic               ok,
  output logic               found,
  output logic [POS_W-1:0]   found_position,
  output logic [KEY_W-1:0]   title_out,
  output logic [WORD_W-1:0]  play_time_out,
  output logic [WORD_W-1:0]  payload_out,
  output logic [COUNT_W-1:0] count
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: decodes the op, walks shifts and searches one entry a cycle
  oal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // entry RAMs, count, operand latch, compare and result registers
  oal_dp #(
    .DEPTH      (DEPTH),
    .TITLE_BITS (TITLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .position       (position),
    .append         (append),
    .title_key      (title_key),
    .play_time_in   (play_time_in),
    .payload_in     (payload_in),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .ok             (ok),
    .found          (found),
    .found_position (found_position),
    .title_out      (title_out),
    .play_time_out  (play_time_out),
    .payload_out    (payload_out),
    .count          (count)
  );

endmodule
